// ===== hdl/hla_pkg.sv =====
`default_nettype none
package hla_pkg;

    // Fixed heap layout constants
    localparam int unsigned HEAP_WORDS_DEF = 16384;
    localparam int unsigned CHUNK_RESET    = 4096;
    localparam int unsigned MIN_BLOCK      = 16;
    localparam int unsigned TAG_BYTES      = 8;
    localparam int unsigned CHUNK_W        = 17;
    localparam int unsigned WQ_DEPTH       = 4;

    // Request kinds
    localparam logic [1:0] KIND_ALLOC   = 2'd0;
    localparam logic [1:0] KIND_FREE    = 2'd1;
    localparam logic [1:0] KIND_REALLOC = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OOM  = 2'd1;
    localparam logic [1:0] ST_NULL = 2'd2;

    // Sequencer states
    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_TAKE,
        S_FF,
        S_EXT,
        S_M0,
        S_M1,
        S_M2,
        S_M3,
        S_M4,
        S_CARVE0,
        S_CARVE,
        S_REL0,
        S_REL1,
        S_CHK,
        S_CHK1,
        S_CHK2,
        S_GROWIN,
        S_WQ,
        S_DONE
    } state_t;

    // Where a coalesce pass was entered from
    typedef enum logic {
        MCTX_GROW,
        MCTX_REL
    } mctx_t;

    typedef struct packed {
        logic [15:0] result_addr;
        logic [1:0]  status;
        logic [15:0] copy_from;
        logic [15:0] copy_len;
    } result_t;

    // Byte address width with headroom for address plus size sums
    function automatic int unsigned addr_bits(int unsigned words);
        int unsigned a;
        a = $clog2(words) + 2;
        if (a < CHUNK_W) begin
            a = CHUNK_W;
        end
        return a + 2;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/hla_heap_mem.sv =====
`default_nettype none
module hla_heap_mem import hla_pkg::*; #(
    parameter int unsigned HEAP_WORDS = HEAP_WORDS_DEF
) (
    input  wire                                 aclk,
    input  wire                                 we,
    input  wire  [addr_bits(HEAP_WORDS)-1:0]    waddr,
    input  wire  [31:0]                         wdata,
    input  wire                                 re,
    input  wire  [addr_bits(HEAP_WORDS)-1:0]    raddr,
    output logic [31:0]                         rdata
);
    localparam int unsigned W  = addr_bits(HEAP_WORDS);
    localparam int unsigned IW = $clog2(HEAP_WORDS);
    localparam logic [W-3:0] LAST_WORD = (W-2)'(HEAP_WORDS);

    logic [31:0] mem [HEAP_WORDS];
    logic [31:0] rd_data_reg;
    logic        oob_reg;
    logic        w_in;
    logic        r_in;

    // Accesses past the end: writes dropped, reads give zero
    assign w_in = waddr[W-1:2] < LAST_WORD;
    assign r_in = raddr[W-1:2] < LAST_WORD;

    always_ff @(posedge aclk) begin
        if (we && w_in) begin
            mem[waddr[IW+1:2]] <= wdata;
        end
        if (re) begin
            rd_data_reg <= mem[raddr[IW+1:2]];
            oob_reg     <= !r_in;
        end
    end

    assign rdata = oob_reg ? 32'd0 : rd_data_reg;

endmodule
`default_nettype wire

// ===== hdl/hla_ctrl.sv =====
`default_nettype none
module hla_ctrl import hla_pkg::*; #(
    parameter int unsigned HEAP_WORDS = HEAP_WORDS_DEF
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 in_valid,
    output logic                                in_ready,
    input  wire  [1:0]                          in_kind,
    input  wire  [15:0]                         in_addr,
    input  wire  [15:0]                         in_size,
    input  wire  [CHUNK_W-1:0]                  chunk,
    output logic                                res_valid,
    input  wire                                 res_ack,
    output result_t                             res,
    output logic                                mem_we,
    output logic [addr_bits(HEAP_WORDS)-1:0]    mem_waddr,
    output logic [31:0]                         mem_wdata,
    output logic                                mem_re,
    output logic [addr_bits(HEAP_WORDS)-1:0]    mem_raddr,
    input  wire  [31:0]                         mem_rdata
);
    localparam int unsigned W  = addr_bits(HEAP_WORDS);
    localparam int unsigned IW = $clog2(HEAP_WORDS);
    localparam logic [W-1:0] HEAP_BYTES = W'(HEAP_WORDS * 4);
    localparam bit FITS = (HEAP_WORDS * 4) >= (16 + CHUNK_RESET);
    localparam logic [W-1:0] BRK_RESET = FITS ? W'(16 + CHUNK_RESET) : W'(16);
    localparam logic [W-1:0] ALIGN_MASK = ~W'(7);

    state_t state_reg, state_next;
    state_t wq_ret_reg, wq_ret_next;
    mctx_t  mctx_reg, mctx_next;

    logic [IW-1:0] clr_reg, clr_next;
    logic [W-1:0]  brk_reg, brk_next;
    logic [W-1:0]  bp_reg, bp_next;
    logic [W-1:0]  addr_reg, addr_next;
    logic [W-1:0]  size_reg, size_next;
    logic [W-1:0]  need_reg, need_next;
    logic [W-1:0]  s_reg, s_next;
    logic [31:0]   h_reg, h_next;
    logic [W-1:0]  msz_reg, msz_next;
    logic [W-1:0]  pfs_reg, pfs_next;
    logic          pu_reg, pu_next;
    logic [W-1:0]  nx_reg, nx_next;
    logic [W-1:0]  nsz_reg, nsz_next;
    logic          nu_reg, nu_next;
    logic [W-1:0]  copy_reg, copy_next;
    logic [W-1:0]  res_reg, res_next;
    logic [1:0]    st_reg, st_next;
    logic [15:0]   cf_reg, cf_next;
    logic [15:0]   cl_reg, cl_next;
    logic          move_reg, move_next;
    logic [1:0]    kind_reg, kind_next;

    // Pending tag writes, drained one a cycle
    logic [W-1:0]  wq_a_reg [WQ_DEPTH];
    logic [W-1:0]  wq_a_next [WQ_DEPTH];
    logic [W-1:0]  wq_d_reg [WQ_DEPTH];
    logic [W-1:0]  wq_d_next [WQ_DEPTH];
    logic [2:0]    wq_cnt_reg, wq_cnt_next;
    logic [1:0]    wq_idx_reg, wq_idx_next;

    logic [31:0]   d;
    logic [W-1:0]  dsz;
    logic [31:0]   init_word;
    logic [W-1:0]  ext;
    logic [W-1:0]  grow_b;
    logic [W-1:0]  total;
    logic [W-1:0]  remain;
    logic [W-1:0]  used;
    logic [W-1:0]  pv;
    state_t        mret;

    assign d   = mem_rdata;
    assign dsz = d[W-1:0] & ALIGN_MASK;

    // Initial heap image: pad, prologue, first free chunk, epilogue
    always_comb begin
        init_word = 32'd0;
        if (clr_reg == IW'(1) || clr_reg == IW'(2)) begin
            init_word = 32'(TAG_BYTES + 1);
        end else if (clr_reg == IW'(3)) begin
            init_word = FITS ? 32'(CHUNK_RESET) : 32'd1;
        end else if (FITS && clr_reg == IW'(1026)) begin
            init_word = 32'(CHUNK_RESET);
        end else if (FITS && clr_reg == IW'(1027)) begin
            init_word = 32'd1;
        end
    end

    // Growth amount: max(need, chunk) rounded to an even word count
    always_comb begin
        ext    = (need_reg > W'(chunk)) ? need_reg : W'(chunk);
        grow_b = (ext & ALIGN_MASK) + (ext[2] ? W'(8) : W'(0));
    end

    always_comb begin
        state_next  = state_reg;
        wq_ret_next = wq_ret_reg;
        mctx_next   = mctx_reg;
        clr_next    = clr_reg;
        brk_next    = brk_reg;
        bp_next     = bp_reg;
        addr_next   = addr_reg;
        size_next   = size_reg;
        need_next   = need_reg;
        s_next      = s_reg;
        h_next      = h_reg;
        msz_next    = msz_reg;
        pfs_next    = pfs_reg;
        pu_next     = pu_reg;
        nx_next     = nx_reg;
        nsz_next    = nsz_reg;
        nu_next     = nu_reg;
        copy_next   = copy_reg;
        res_next    = res_reg;
        st_next     = st_reg;
        cf_next     = cf_reg;
        cl_next     = cl_reg;
        move_next   = move_reg;
        kind_next   = kind_reg;
        wq_a_next   = wq_a_reg;
        wq_d_next   = wq_d_reg;
        wq_cnt_next = wq_cnt_reg;
        wq_idx_next = wq_idx_reg;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = 32'd0;
        mem_re      = 1'b0;
        mem_raddr   = '0;
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        total       = '0;
        remain      = '0;
        used        = '0;
        pv          = '0;
        mret        = (mctx_reg == MCTX_GROW) ? S_CARVE0 : S_DONE;

        unique case (state_reg)
            // Sweep the memory once after reset
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = W'({clr_reg, 2'b00});
                mem_wdata = init_word;
                clr_next  = clr_reg + IW'(1);
                if (clr_reg == IW'(HEAP_WORDS - 1)) begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    kind_next = in_kind;
                    addr_next = W'(in_addr);
                    res_next  = '0;
                    st_next   = ST_OK;
                    cf_next   = 16'd0;
                    cl_next   = 16'd0;
                    move_next = 1'b0;
                    case (in_kind)
                        KIND_ALLOC: begin
                            size_next  = W'(in_size);
                            state_next = S_TAKE;
                        end
                        KIND_FREE: begin
                            state_next = S_CHK;
                        end
                        KIND_REALLOC: begin
                            size_next  = (W'(in_size) + W'(7)) & ALIGN_MASK;
                            state_next = (in_addr == 16'd0) ? S_TAKE : S_CHK;
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // Allocation: round, then first-fit walk from the prologue
            S_TAKE: begin
                if (size_reg == '0) begin
                    st_next    = ST_NULL;
                    state_next = S_DONE;
                end else begin
                    need_next  = (size_reg + W'(TAG_BYTES + 7)) & ALIGN_MASK;
                    bp_next    = W'(8);
                    mem_re     = 1'b1;
                    mem_raddr  = W'(4);
                    state_next = S_FF;
                end
            end

            // One header a cycle
            S_FF: begin
                if (dsz == '0) begin
                    state_next = S_EXT;
                end else if (!d[0] && dsz >= need_reg) begin
                    state_next = S_CARVE0;
                end else if (bp_reg + dsz >= brk_reg) begin
                    state_next = S_EXT;
                end else begin
                    bp_next   = bp_reg + dsz;
                    mem_re    = 1'b1;
                    mem_raddr = bp_reg + dsz - W'(4);
                end
            end

            // No fit: extend the break
            S_EXT: begin
                if (brk_reg + grow_b > HEAP_BYTES) begin
                    st_next    = ST_OOM;
                    res_next   = '0;
                    state_next = S_DONE;
                end else begin
                    wq_a_next[0] = brk_reg - W'(4);
                    wq_d_next[0] = grow_b;
                    wq_a_next[1] = brk_reg + grow_b - W'(8);
                    wq_d_next[1] = grow_b;
                    wq_a_next[2] = brk_reg + grow_b - W'(4);
                    wq_d_next[2] = W'(1);
                    wq_cnt_next  = 3'd3;
                    wq_idx_next  = 2'd0;
                    bp_next      = brk_reg;
                    brk_next     = brk_reg + grow_b;
                    mctx_next    = MCTX_GROW;
                    wq_ret_next  = S_M0;
                    state_next   = S_WQ;
                end
            end

            // Coalesce around bp
            S_M0: begin
                mem_re     = 1'b1;
                mem_raddr  = bp_reg - W'(4);
                state_next = S_M1;
            end

            S_M1: begin
                msz_next   = dsz;
                mem_re     = 1'b1;
                mem_raddr  = bp_reg - W'(8);
                state_next = S_M2;
            end

            S_M2: begin
                pu_next    = d[0];
                pfs_next   = dsz;
                nx_next    = bp_reg + msz_reg;
                mem_re     = 1'b1;
                mem_raddr  = bp_reg + msz_reg - W'(4);
                state_next = S_M3;
            end

            S_M3: begin
                nu_next  = d[0];
                nsz_next = dsz;
                if (pu_reg && d[0]) begin
                    state_next = mret;
                end else if (pu_reg) begin
                    total        = msz_reg + dsz;
                    wq_a_next[0] = bp_reg - W'(4);
                    wq_d_next[0] = total;
                    wq_a_next[1] = nx_reg + dsz - W'(8);
                    wq_d_next[1] = total;
                    wq_cnt_next  = 3'd2;
                    wq_idx_next  = 2'd0;
                    wq_ret_next  = mret;
                    state_next   = S_WQ;
                end else begin
                    mem_re     = 1'b1;
                    mem_raddr  = bp_reg - pfs_reg - W'(4);
                    state_next = S_M4;
                end
            end

            // Previous block free: merge downwards
            S_M4: begin
                pv = bp_reg - pfs_reg;
                if (nu_reg) begin
                    total        = dsz + msz_reg;
                    wq_a_next[0] = nx_reg - W'(8);
                    wq_d_next[0] = total;
                    wq_a_next[1] = pv - W'(4);
                    wq_d_next[1] = total;
                end else begin
                    total        = dsz + msz_reg + nsz_reg;
                    wq_a_next[0] = pv - W'(4);
                    wq_d_next[0] = total;
                    wq_a_next[1] = nx_reg + nsz_reg - W'(8);
                    wq_d_next[1] = total;
                end
                wq_cnt_next = 3'd2;
                wq_idx_next = 2'd0;
                bp_next     = pv;
                wq_ret_next = mret;
                state_next  = S_WQ;
            end

            S_CARVE0: begin
                mem_re     = 1'b1;
                mem_raddr  = bp_reg - W'(4);
                state_next = S_CARVE;
            end

            // Mark used, splitting off a remainder of at least a minimum block
            S_CARVE: begin
                if (dsz < need_reg + W'(MIN_BLOCK)) begin
                    wq_a_next[0] = bp_reg - W'(4);
                    wq_d_next[0] = dsz | W'(1);
                    wq_a_next[1] = bp_reg + dsz - W'(8);
                    wq_d_next[1] = dsz | W'(1);
                    wq_cnt_next  = 3'd2;
                end else begin
                    wq_a_next[0] = bp_reg - W'(4);
                    wq_d_next[0] = need_reg | W'(1);
                    wq_a_next[1] = bp_reg + need_reg - W'(8);
                    wq_d_next[1] = need_reg | W'(1);
                    wq_a_next[2] = bp_reg + need_reg - W'(4);
                    wq_d_next[2] = dsz - need_reg;
                    wq_a_next[3] = bp_reg + dsz - W'(8);
                    wq_d_next[3] = dsz - need_reg;
                    wq_cnt_next  = 3'd4;
                end
                wq_idx_next = 2'd0;
                res_next    = bp_reg;
                st_next     = ST_OK;
                if (move_reg) begin
                    cf_next     = addr_reg[15:0];
                    cl_next     = copy_reg[15:0];
                    bp_next     = addr_reg;
                    wq_ret_next = S_REL0;
                end else begin
                    wq_ret_next = S_DONE;
                end
                state_next = S_WQ;
            end

            // Release: clear the used bit, then coalesce
            S_REL0: begin
                mem_re     = 1'b1;
                mem_raddr  = bp_reg - W'(4);
                state_next = S_REL1;
            end

            S_REL1: begin
                wq_a_next[0] = bp_reg - W'(4);
                wq_d_next[0] = dsz;
                wq_a_next[1] = bp_reg + dsz - W'(8);
                wq_d_next[1] = dsz;
                wq_cnt_next  = 3'd2;
                wq_idx_next  = 2'd0;
                mctx_next    = MCTX_REL;
                wq_ret_next  = S_M0;
                state_next   = S_WQ;
            end

            // Block check: address range, header, footer
            S_CHK: begin
                if (addr_reg != '0 && addr_reg[2:0] == 3'd0 &&
                    addr_reg >= W'(MIN_BLOCK) && addr_reg < brk_reg) begin
                    bp_next    = addr_reg;
                    mem_re     = 1'b1;
                    mem_raddr  = addr_reg - W'(4);
                    state_next = S_CHK1;
                end else begin
                    state_next = S_DONE;
                end
            end

            S_CHK1: begin
                h_next = d;
                s_next = dsz;
                if (!d[0] || dsz < W'(MIN_BLOCK) || bp_reg + dsz > brk_reg) begin
                    state_next = S_DONE;
                end else begin
                    mem_re     = 1'b1;
                    mem_raddr  = bp_reg + dsz - W'(8);
                    state_next = S_CHK2;
                end
            end

            S_CHK2: begin
                if (d != h_reg) begin
                    state_next = S_DONE;
                end else if (kind_reg == KIND_FREE) begin
                    state_next = S_REL0;
                end else if (size_reg == '0) begin
                    st_next    = ST_NULL;
                    state_next = S_REL0;
                end else begin
                    copy_next = s_reg - W'(TAG_BYTES);
                    if (size_reg <= s_reg - W'(TAG_BYTES)) begin
                        need_next  = size_reg + W'(TAG_BYTES);
                        state_next = S_CARVE0;
                    end else begin
                        nx_next    = bp_reg + s_reg;
                        mem_re     = 1'b1;
                        mem_raddr  = bp_reg + s_reg - W'(4);
                        state_next = S_GROWIN;
                    end
                end
            end

            // Grow into a free successor, or move
            S_GROWIN: begin
                total  = dsz + s_reg;
                used   = size_reg + W'(TAG_BYTES);
                remain = total - used;
                if (!d[0] && dsz + copy_reg >= size_reg) begin
                    if (remain >= W'(MIN_BLOCK)) begin
                        wq_a_next[0] = bp_reg - W'(4);
                        wq_d_next[0] = used | W'(1);
                        wq_a_next[1] = bp_reg + used - W'(8);
                        wq_d_next[1] = used | W'(1);
                        wq_a_next[2] = bp_reg + used - W'(4);
                        wq_d_next[2] = remain;
                        wq_a_next[3] = bp_reg + total - W'(8);
                        wq_d_next[3] = remain;
                        wq_cnt_next  = 3'd4;
                    end else begin
                        wq_a_next[0] = bp_reg - W'(4);
                        wq_d_next[0] = total | W'(1);
                        wq_a_next[1] = bp_reg + total - W'(8);
                        wq_d_next[1] = total | W'(1);
                        wq_cnt_next  = 3'd2;
                    end
                    wq_idx_next = 2'd0;
                    res_next    = bp_reg;
                    wq_ret_next = S_DONE;
                    state_next  = S_WQ;
                end else begin
                    move_next  = 1'b1;
                    state_next = S_TAKE;
                end
            end

            S_WQ: begin
                mem_we      = 1'b1;
                mem_waddr   = wq_a_reg[wq_idx_reg];
                mem_wdata   = 32'(wq_d_reg[wq_idx_reg]);
                wq_idx_next = wq_idx_reg + 2'd1;
                if ({1'b0, wq_idx_reg} == wq_cnt_reg - 3'd1) begin
                    state_next = wq_ret_reg;
                end
            end

            S_DONE: begin
                res_valid = 1'b1;
                if (res_ack) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res.result_addr = res_reg[15:0];
    assign res.status      = st_reg;
    assign res.copy_from   = cf_reg;
    assign res.copy_len    = cl_reg;

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            brk_reg     <= BRK_RESET;
            wq_cnt_reg  <= 3'd1;
            wq_idx_reg  <= 2'd0;
            wq_ret_reg  <= S_IDLE;
            mctx_reg    <= MCTX_REL;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            brk_reg     <= brk_next;
            wq_cnt_reg  <= wq_cnt_next;
            wq_idx_reg  <= wq_idx_next;
            wq_ret_reg  <= wq_ret_next;
            mctx_reg    <= mctx_next;
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        bp_reg   <= bp_next;
        addr_reg <= addr_next;
        size_reg <= size_next;
        need_reg <= need_next;
        s_reg    <= s_next;
        h_reg    <= h_next;
        msz_reg  <= msz_next;
        pfs_reg  <= pfs_next;
        pu_reg   <= pu_next;
        nx_reg   <= nx_next;
        nsz_reg  <= nsz_next;
        nu_reg   <= nu_next;
        copy_reg <= copy_next;
        res_reg  <= res_next;
        st_reg   <= st_next;
        cf_reg   <= cf_next;
        cl_reg   <= cl_next;
        move_reg <= move_next;
        kind_reg <= kind_next;
        wq_a_reg <= wq_a_next;
        wq_d_reg <= wq_d_next;
    end

endmodule
`default_nettype wire

// ===== hdl/implicit_list_heap_allocator_unit.sv =====
// Heap allocator over a word memory of boundary-tagged blocks.
// Input words (s_*): tuser carries the request kind (allocate, free,
// reallocate); tdata carries the block's payload offset and requested size.
// Each accepted word gives exactly one result word (m_*): granted offset,
// status, and for a moved reallocation the copy source and length. The
// payload copy itself is up to the caller.
// One request at a time. An allocation walks the block headers one per
// memory read cycle, growing the break and coalescing when no block fits,
// and splits the block when the remainder allows. A free checks the block,
// clears its used bit and coalesces; a reallocation may do both an
// allocation and a free. The heap memory takes one access per cycle and
// its reads are registered.
// After reset the heap memory is swept, one word per cycle, laying down
// the prologue, first free chunk and epilogue; s_tready stays low during
// the sweep. cfg_we may be used at any time the block is idle and sets the
// least break growth in bytes.
// The result sits in an output register; the next request is taken while
// it waits, and a stalled m_tready holds it and the following one.
`default_nettype none
module implicit_list_heap_allocator_unit import hla_pkg::*; #(
    parameter int unsigned HEAP_WORDS = HEAP_WORDS_DEF
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  wire  [31:0]         s_tdata,   // block_addr [15:0], req_size [31:16]
    input  wire  [1:0]          s_tuser,   // kind [1:0]
    output logic                m_tvalid,
    input  wire                 m_tready,
    output logic [55:0]         m_tdata,   // result_addr [15:0], status [17:16],
                                           // copy_from [33:18], copy_len [49:34]
    input  wire                 cfg_we,
    input  wire  [CHUNK_W-1:0]  cfg_wdata
);
    localparam int unsigned W = addr_bits(HEAP_WORDS);

    logic [CHUNK_W-1:0] chunk_reg;
    logic               m_tvalid_reg;
    logic [55:0]        m_tdata_reg;
    logic               res_valid;
    logic               res_ack;
    result_t            res;
    logic               mem_we;
    logic [W-1:0]       mem_waddr;
    logic [31:0]        mem_wdata;
    logic               mem_re;
    logic [W-1:0]       mem_raddr;
    logic [31:0]        mem_rdata;

    // Growth chunk register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chunk_reg <= CHUNK_W'(CHUNK_RESET);
        end else if (cfg_we) begin
            chunk_reg <= cfg_wdata;
        end
    end

    hla_ctrl #(
        .HEAP_WORDS (HEAP_WORDS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (s_tuser),
        .in_addr   (s_tdata[15:0]),
        .in_size   (s_tdata[31:16]),
        .chunk     (chunk_reg),
        .res_valid (res_valid),
        .res_ack   (res_ack),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    hla_heap_mem #(
        .HEAP_WORDS (HEAP_WORDS)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Output register
    assign res_ack = res_valid && (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ack) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ack) begin
            m_tdata_reg <= {6'd0, res.copy_len, res.copy_from, res.status, res.result_addr};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
module tb_top import hla_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned NWORDS = HEAP_WORDS_DEF;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [31:0]         s_tdata = '0;
    logic [1:0]          s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [55:0]         m_tdata;
    logic                cfg_we = 1'b0;
    logic [CHUNK_W-1:0]  cfg_wdata = '0;

    implicit_list_heap_allocator_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // run limit
    initial begin
        #100ms;
        $display("Mismatches found");
        $finish;
    end

    // Shadow heap
    logic [31:0]     heap_mem [NWORDS];
    longint unsigned heap_brk;
    int unsigned     grow_chunk;

    result_t     pending_results[$];
    longint unsigned live_blocks[$];
    int          n_errors = 0;
    int          tx_idle = 0;
    int          rx_idle = 0;
    int          rx_hold = 0;

    function automatic int unsigned mrd(longint unsigned a);
        longint unsigned w;
        w = a >> 2;
        if (w >= NWORDS) return 0;
        return heap_mem[w];
    endfunction

    function automatic void mwr(longint unsigned a, int unsigned v);
        longint unsigned w;
        w = a >> 2;
        if (w < NWORDS) heap_mem[w] = v;
    endfunction

    function automatic int unsigned tsize(longint unsigned a);
        return mrd(a) & ~32'h7;
    endfunction

    function automatic int unsigned tused(longint unsigned a);
        return mrd(a) & 32'h1;
    endfunction

    function automatic int unsigned align8(int unsigned n);
        return (n + 7) & ~32'h7;
    endfunction

    // merge with free neighbours, four cases
    function automatic longint unsigned coalesce(longint unsigned bp);
        int unsigned sz, pu, nu, nsz, psz, total;
        longint unsigned nx, pv;
        sz  = tsize(bp - 4);
        pu  = tused(bp - 8);
        nx  = bp + sz;
        nu  = tused(nx - 4);
        nsz = tsize(nx - 4);
        pv  = bp - tsize(bp - 8);
        psz = tsize(pv - 4);
        if (pu && nu) return bp;
        if (pu) begin
            total = sz + nsz;
            mwr(bp - 4, total);
            mwr(bp + total - 8, total);
            return bp;
        end
        if (nu) begin
            total = psz + sz;
            mwr(bp + sz - 8, total);
            mwr(pv - 4, total);
            return pv;
        end
        total = psz + sz + nsz;
        mwr(pv - 4, total);
        mwr(nx + nsz - 8, total);
        return pv;
    endfunction

    function automatic longint unsigned grow_break(int unsigned bytes);
        longint unsigned bp;
        bp = heap_brk;
        if (bp + bytes > longint'(NWORDS) * 4) return 0;
        mwr(bp - 4, bytes);
        mwr(bp + bytes - 8, bytes);
        mwr(bp + bytes - 4, 1);
        heap_brk += bytes;
        return coalesce(bp);
    endfunction

    function automatic longint unsigned first_free(int unsigned need);
        longint unsigned bp;
        int unsigned s;
        bp = 8;
        while (bp < heap_brk) begin
            s = tsize(bp - 4);
            if (s == 0) break;
            if (!tused(bp - 4) && s >= need) return bp;
            bp += s;
        end
        return 0;
    endfunction

    function automatic void place(longint unsigned bp, int unsigned need);
        int unsigned cap;
        cap = tsize(bp - 4);
        if (longint'(cap) < longint'(need) + MIN_BLOCK) begin
            mwr(bp - 4, cap | 1);
            mwr(bp + cap - 8, cap | 1);
        end else begin
            mwr(bp - 4, need | 1);
            mwr(bp + need - 8, need | 1);
            mwr(bp + need - 4, cap - need);
            mwr(bp + cap - 8, cap - need);
        end
    endfunction

    function automatic longint unsigned grant(int unsigned req, output logic [1:0] st);
        int unsigned need, ext, words;
        longint unsigned bp;
        if (req == 0) begin
            st = ST_NULL;
            return 0;
        end
        need = align8(req + TAG_BYTES);
        bp = first_free(need);
        if (bp == 0) begin
            ext = (need > grow_chunk) ? need : grow_chunk;
            words = ext / 4;
            bp = grow_break((words + (words & 1)) * 4);
            if (bp == 0) begin
                st = ST_OOM;
                return 0;
            end
        end
        place(bp, need);
        st = ST_OK;
        return bp;
    endfunction

    function automatic void release_block(longint unsigned bp);
        int unsigned s;
        s = tsize(bp - 4);
        mwr(bp - 4, s);
        mwr(bp + s - 8, s);
        void'(coalesce(bp));
    endfunction

    function automatic bit valid_block(longint unsigned bp);
        int unsigned h, s;
        if (bp == 0 || bp[2:0] != 0 || bp < 16 || bp >= heap_brk) return 0;
        h = mrd(bp - 4);
        if (!h[0]) return 0;
        s = h & ~32'h7;
        if (s < MIN_BLOCK || bp + s > heap_brk) return 0;
        return mrd(bp + s - 8) == h;
    endfunction

    function automatic void heap_reset();
        foreach (heap_mem[i]) heap_mem[i] = '0;
        grow_chunk = CHUNK_RESET;
        mwr(4, TAG_BYTES | 1);
        mwr(8, TAG_BYTES | 1);
        mwr(12, 1);
        heap_brk = 16;
        void'(grow_break(CHUNK_RESET));
    endfunction

    // expected result word for one request
    function automatic result_t predict_request(logic [1:0] kind, logic [15:0] addr_in,
                                                logic [15:0] req_in);
        result_t r;
        longint unsigned addr, res, cf, cl, nx, n;
        int unsigned size, copy, ns, total, remain, used;
        logic [1:0] st;
        addr = addr_in;
        res = 0; cf = 0; cl = 0; st = ST_OK;
        if (kind == KIND_ALLOC) begin
            res = grant(req_in, st);
        end else if (kind == KIND_FREE) begin
            if (valid_block(addr)) release_block(addr);
        end else if (kind == KIND_REALLOC) begin
            size = align8(req_in);
            if (addr == 0) begin
                res = grant(size, st);
            end else if (valid_block(addr)) begin
                if (size == 0) begin
                    release_block(addr);
                    st = ST_NULL;
                end else begin
                    copy = tsize(addr - 4) - TAG_BYTES;
                    if (size <= copy) begin
                        place(addr, size + TAG_BYTES);
                        res = addr;
                    end else begin
                        nx = addr + tsize(addr - 4);
                        ns = tsize(nx - 4);
                        if (!tused(nx - 4) && longint'(ns) + copy >= size) begin
                            // grow into the free block that follows
                            total = ns + copy + TAG_BYTES;
                            remain = total - size - TAG_BYTES;
                            if (remain >= MIN_BLOCK) begin
                                used = size + TAG_BYTES;
                                mwr(addr - 4, used | 1);
                                mwr(addr + used - 8, used | 1);
                                mwr(addr + used - 4, remain);
                                mwr(addr + total - 8, remain);
                            end else begin
                                mwr(addr - 4, total | 1);
                                mwr(addr + total - 8, total | 1);
                            end
                            res = addr;
                        end else begin
                            n = grant(size, st);
                            if (n != 0) begin
                                cf = addr;
                                cl = copy;
                                release_block(addr);
                                res = n;
                            end
                        end
                    end
                end
            end
        end
        r.result_addr = res[15:0];
        r.status      = st;
        r.copy_from   = cf[15:0];
        r.copy_len    = cl[15:0];
        return r;
    endfunction

    // Receiver: random ready, long hold-off on request, result check
    always @(posedge aclk) begin
        result_t exp_r;
        if (m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result word with no request outstanding");
                n_errors++;
            end else begin
                exp_r = pending_results.pop_front();
                if (m_tdata[15:0] !== exp_r.result_addr) begin
                    $error("result_addr: expected %0d, got %0d", exp_r.result_addr, m_tdata[15:0]);
                    n_errors++;
                end
                if (m_tdata[17:16] !== exp_r.status) begin
                    $error("status: expected %0d, got %0d", exp_r.status, m_tdata[17:16]);
                    n_errors++;
                end
                if (m_tdata[33:18] !== exp_r.copy_from) begin
                    $error("copy_from: expected %0d, got %0d", exp_r.copy_from, m_tdata[33:18]);
                    n_errors++;
                end
                if (m_tdata[49:34] !== exp_r.copy_len) begin
                    $error("copy_len: expected %0d, got %0d", exp_r.copy_len, m_tdata[49:34]);
                    n_errors++;
                end
            end
        end
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle);
        end
    end

    // keep the list of live blocks in step with the shadow heap
    function automatic void track_blocks(result_t r);
        longint unsigned keep[$];
        bit seen;
        seen = 0;
        foreach (live_blocks[i]) begin
            if (valid_block(live_blocks[i])) keep.push_back(live_blocks[i]);
            if (live_blocks[i] == r.result_addr) seen = 1;
        end
        if (r.status == ST_OK && r.result_addr != 0 && !seen)
            keep.push_back(r.result_addr);
        live_blocks = keep;
    endfunction

    task automatic send_word(logic [1:0] kind, logic [15:0] addr, logic [15:0] req);
        result_t r;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {req, addr};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = predict_request(kind, addr, req);
        pending_results.push_back(r);
        track_blocks(r);
        if ($urandom_range(99) < tx_idle) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_chunk(int unsigned bytes);
        cfg_we    <= 1'b1;
        cfg_wdata <= bytes[CHUNK_W-1:0];
        @(posedge aclk);
        cfg_we    <= 1'b0;
        grow_chunk = bytes & 32'h1FFFF;
        @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_live();
        if (live_blocks.size() == 0) return 16'd16;
        return 16'(live_blocks[$urandom_range(live_blocks.size() - 1)]);
    endfunction

    function automatic logic [15:0] rand_size();
        int unsigned p;
        p = $urandom_range(99);
        if (p < 70) return 16'($urandom_range(1, 120));
        if (p < 95) return 16'($urandom_range(121, 1500));
        if (p < 98) return 16'($urandom_range(1501, 9000));
        return 16'($urandom);
    endfunction

    // null, bad address, unused kind and realloc paths
    task automatic test_directed();
        logic [15:0] a, b;
        send_word(KIND_ALLOC, 16'd0, 16'd0);
        send_word(KIND_ALLOC, 16'd0, 16'hFFFF);
        send_word(KIND_ALLOC, 16'hFFFF, 16'd1);
        send_word(KIND_ALLOC, 16'd0, 16'd100);
        send_word(KIND_ALLOC, 16'd0, 16'd40);
        send_word(KIND_FREE, 16'd0, 16'd0);
        send_word(KIND_FREE, 16'd3, 16'hFFFF);
        send_word(KIND_FREE, 16'd8, 16'd0);
        send_word(KIND_FREE, 16'hFFF8, 16'd0);
        send_word(KIND_UNUSED, 16'hFFFF, 16'hFFFF);
        send_word(KIND_REALLOC, 16'd0, 16'd0);
        send_word(KIND_REALLOC, 16'd0, 16'd24);
        drain();
        a = pick_live();
        b = 16'(live_blocks[0]);
        send_word(KIND_REALLOC, b, 16'd8);        // fits in place, no split
        send_word(KIND_REALLOC, b, 16'd200);      // move, the next block being in use
        send_word(KIND_FREE, b, 16'd0);
        send_word(KIND_FREE, b, 16'd0);           // double free ignored
        send_word(KIND_REALLOC, a, 16'd3000);     // grow in place or move
        drain();
        send_word(KIND_REALLOC, pick_live(), 16'd0);
        send_word(KIND_ALLOC, 16'd0, 16'd4000);
        send_word(KIND_ALLOC, 16'd0, 16'd60000);  // out of memory
        send_word(KIND_REALLOC, pick_live(), 16'hFFFF);
        drain();
    endtask

    task automatic random_word();
        int unsigned p;
        p = $urandom_range(99);
        if (live_blocks.size() > 40 && p < 45) p = 50;
        if (p < 45)      send_word(KIND_ALLOC, 16'($urandom), rand_size());
        else if (p < 70) send_word(KIND_FREE, pick_live(), 16'($urandom));
        else if (p < 88) send_word(KIND_REALLOC, pick_live(), rand_size());
        else if (p < 92) send_word(KIND_REALLOC, 16'd0, rand_size());
        else if (p < 96) send_word(2'($urandom_range(KIND_FREE, KIND_REALLOC)),
                                   16'($urandom), 16'($urandom));
        else             send_word(KIND_UNUSED, 16'($urandom), 16'($urandom));
    endtask

    task automatic test_random(int tx, int rx, int count);
        tx_idle = tx;
        rx_idle = rx;
        repeat (count) random_word();
        drain();
    endtask

    // growth extremes: a chunk of one minimum block, a chunk as large as the heap
    task automatic test_chunk_settings();
        write_chunk(16);
        test_random(10, 10, 120);
        write_chunk(65536);
        test_random(10, 10, 80);
        write_chunk($urandom_range(16, 20000));
        test_random(10, 10, 120);
        write_chunk(4096);
    endtask

    // receiver holds off while requests keep coming, then both sides run without idles
    task automatic test_backpressure();
        tx_idle = 0;
        rx_idle = 0;
        rx_hold = 400;
        repeat (12) random_word();
        drain();
        repeat (20) random_word();
        drain();
    endtask

    initial begin
        heap_reset();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        write_chunk(4096);
        test_directed();
        test_chunk_settings();
        test_random(38, 71, 500);
        test_random(71, 38, 500);
        test_backpressure();
        test_random(0, 0, 500);
        drain();
        if (n_errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/hla_pkg.sv
hdl/hla_heap_mem.sv
hdl/hla_ctrl.sv
hdl/implicit_list_heap_allocator_unit.sv
bench/tb_top.sv
